/* hdl/utf8d_pkg.sv */
// Shared types and constants of the UTF-8 byte stream decoder.
// Used by the front, the queue and the back; depends on nothing.
package utf8d_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int ST_W   = 3;

    // Byte classes, fixed by the front from the byte value and the end marker alone.
    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_LEAD2 = 3'd1,
        CLS_LEAD3 = 3'd2,
        CLS_LEAD4 = 3'd3,
        CLS_CONT  = 3'd4,
        CLS_BAD   = 3'd5,
        CLS_END   = 3'd6
    } t_class;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_EOF      = 3'd1,
        ST_BAD_LEAD = 3'd2,
        ST_BAD_CONT = 3'd3,
        ST_TRUNC    = 3'd4
    } t_status;

    typedef struct packed {
        t_class            cls;
        logic [BYTE_W-1:0] byte_value;
    } t_entry;

    typedef struct packed {
        logic [CP_W-1:0] scalar_value;
        t_status         status;
        logic            last_of_run;
    } t_result;

    // Queue status seen by the front.
    typedef struct packed {
        logic full;
    } t_queue_status;

endpackage

/* hdl/utf8d_in_if.sv */
// Input channel of the decoder: one byte or an end-of-stream marker per item.
// Depends on nothing.
interface utf8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_marker;

    modport source (output valid, output byte_value, output end_marker, input ready);
    modport sink   (input valid, input byte_value, input end_marker, output ready);
endinterface

/* hdl/utf8d_out_if.sv */
// Output channel of the decoder: one decoded result per item.
// Depends on nothing.
interface utf8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] scalar_value;
    logic [2:0]  status;
    logic        last_of_run;

    modport source (output valid, output scalar_value, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input scalar_value, input status, input last_of_run,
                    output ready);
endinterface

/* hdl/utf8_byte_stream_decoder_unit.sv */
// Channel     Dir  Payload                                    Handshake
// i_in_chan   in   byte_value[7:0], end_marker                valid/ready
// o_out_chan  out  scalar_value[20:0], status[2:0], last_of_run valid/ready
//
// One input item is taken per cycle while the queue is not full; results leave from a registered output.
// A bad continuation byte that also yields a lead result gives two results;
// the second waits in a pending register behind the single output register.
// Reset is synchronous and clears the sequence state, the queue and the output.
// A four-item queue between front and back absorbs output stalls.
//
// Top level of the UTF-8 byte stream decoder: front, queue and back.
// Depends on utf8d_pkg, utf8d_in_if, utf8d_out_if and the three submodules.
module utf8_byte_stream_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utf8d_in_if.sink    i_in_chan,
    utf8d_out_if.source o_out_chan
);

    logic                      push;
    utf8d_pkg::t_entry         push_entry;
    utf8d_pkg::t_queue_status  q_status;
    logic                      pop;
    logic                      head_valid;
    utf8d_pkg::t_entry         head_entry;

    utf8d_front u_front (
        .i_in_chan    (i_in_chan),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_push_entry (push_entry)
    );

    utf8d_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .o_status     (q_status),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_entry (head_entry)
    );

    utf8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_entry (head_entry),
        .o_pop        (pop),
        .o_out_chan   (o_out_chan)
    );

endmodule

/* hdl/utf8d_front.sv */
// Front of the decoder: accepts input items and classes each byte.
// Depends on utf8d_pkg and utf8d_in_if.
module utf8d_front (
    utf8d_in_if.sink               i_in_chan,
    input  utf8d_pkg::t_queue_status i_q_status,
    output logic                   o_push,
    output utf8d_pkg::t_entry      o_push_entry
);

    utf8d_pkg::t_class cls;
    logic [7:0]        b;

    assign b = i_in_chan.byte_value;

    always_comb begin
        priority if (i_in_chan.end_marker) begin
            cls = utf8d_pkg::CLS_END;
        end else if (b <= 8'h7F) begin
            cls = utf8d_pkg::CLS_ASCII;
        end else if (b <= 8'hBF) begin
            cls = utf8d_pkg::CLS_CONT;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
            cls = utf8d_pkg::CLS_LEAD2;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            cls = utf8d_pkg::CLS_LEAD3;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            cls = utf8d_pkg::CLS_LEAD4;
        end else begin
            cls = utf8d_pkg::CLS_BAD;
        end
    end

    assign i_in_chan.ready         = ~i_q_status.full;
    assign o_push                  = i_in_chan.valid & ~i_q_status.full;
    assign o_push_entry.cls        = cls;
    assign o_push_entry.byte_value = b;

endmodule

/* hdl/utf8d_queue.sv */
// Short queue of classed items between the front and the back.
// Depends on utf8d_pkg.
module utf8d_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  utf8d_pkg::t_entry         i_push_entry,
    output utf8d_pkg::t_queue_status  o_status,
    input  logic                      i_pop,
    output logic                      o_head_valid,
    output utf8d_pkg::t_entry         o_head_entry
);

    utf8d_pkg::t_entry                r_mem [utf8d_pkg::QUEUE_DEPTH];
    logic [utf8d_pkg::QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [utf8d_pkg::QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [utf8d_pkg::QUEUE_AW:0]     r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    assign o_status.full = (r_count == (utf8d_pkg::QUEUE_AW+1)'(utf8d_pkg::QUEUE_DEPTH));
    assign o_head_valid  = (r_count != '0);
    assign o_head_entry  = r_mem[r_rd_ptr];

endmodule

/* hdl/utf8d_back.sv */
// Back of the decoder: runs the sequence state and emits results.
// Depends on utf8d_pkg and utf8d_out_if.
module utf8d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  utf8d_pkg::t_entry i_head_entry,
    output logic              o_pop,
    utf8d_out_if.source       o_out_chan
);

    logic [1:0]             r_remain, n_remain;
    logic [20:0]            r_acc, n_acc;
    logic                   r_out_valid, n_out_valid;
    utf8d_pkg::t_result     r_out, n_out;
    logic                   r_pend_valid, n_pend_valid;
    utf8d_pkg::t_result     r_pend, n_pend;

    logic                   can_load;
    logic [7:0]             b;
    logic                   lead_res;
    utf8d_pkg::t_result     lead_r;
    logic [1:0]             lead_rem;
    logic [20:0]            lead_acc;
    logic [20:0]            cont_acc;
    logic                   res1_v, res2_v;
    utf8d_pkg::t_result     res1, res2;

    assign b        = i_head_entry.byte_value;
    assign can_load = ~r_out_valid | o_out_chan.ready;
    // A held second result goes out before the next item is taken.
    assign o_pop    = i_head_valid & can_load & ~r_pend_valid;
    assign cont_acc = {r_acc[14:0], b[5:0]};

    // Decoding of the byte as a lead byte, used while idle and after a broken sequence.
    always_comb begin
        lead_res = 1'b0;
        lead_r   = '{scalar_value: '0, status: utf8d_pkg::ST_BAD_LEAD, last_of_run: 1'b1};
        lead_rem = 2'd0;
        lead_acc = '0;
        unique case (i_head_entry.cls)
            utf8d_pkg::CLS_ASCII: begin
                lead_res = 1'b1;
                lead_r   = '{scalar_value: {14'd0, b[6:0]}, status: utf8d_pkg::ST_OK,
                             last_of_run: 1'b1};
            end
            utf8d_pkg::CLS_LEAD2: begin
                lead_rem = 2'd1;
                lead_acc = {16'd0, b[4:0]};
            end
            utf8d_pkg::CLS_LEAD3: begin
                lead_rem = 2'd2;
                lead_acc = {17'd0, b[3:0]};
            end
            utf8d_pkg::CLS_LEAD4: begin
                lead_rem = 2'd3;
                lead_acc = {18'd0, b[2:0]};
            end
            default: begin
                lead_res = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_remain = r_remain;
        n_acc    = r_acc;
        res1_v   = 1'b0;
        res2_v   = 1'b0;
        res1     = '{scalar_value: '0, status: utf8d_pkg::ST_OK, last_of_run: 1'b1};
        res2     = lead_r;
        priority if (i_head_entry.cls == utf8d_pkg::CLS_END) begin
            res1_v        = 1'b1;
            res1.status   = (r_remain == 2'd0) ? utf8d_pkg::ST_EOF : utf8d_pkg::ST_TRUNC;
            n_remain      = 2'd0;
            n_acc         = '0;
        end else if (r_remain == 2'd0) begin
            res1_v   = lead_res;
            res1     = lead_r;
            n_remain = lead_rem;
            n_acc    = lead_acc;
        end else if (i_head_entry.cls == utf8d_pkg::CLS_CONT) begin
            n_remain = r_remain - 2'd1;
            n_acc    = cont_acc;
            if (r_remain == 2'd1) begin
                res1_v            = 1'b1;
                res1.scalar_value = cont_acc;
                n_acc             = '0;
            end
        end else begin
            // Broken sequence: report it, then take the byte as a new lead.
            res1_v           = 1'b1;
            res1.status      = utf8d_pkg::ST_BAD_CONT;
            res1.last_of_run = ~lead_res;
            res2_v           = lead_res;
            n_remain         = lead_rem;
            n_acc            = lead_acc;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        if (can_load) begin
            n_out_valid = 1'b0;
            if (r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_pend;
                n_pend_valid = 1'b0;
            end else if (o_pop) begin
                n_out_valid  = res1_v;
                n_out        = res1;
                n_pend_valid = res2_v;
                n_pend       = res2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain     <= 2'd0;
            r_acc        <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_remain <= n_remain;
                r_acc    <= n_acc;
            end
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_out_chan.valid        = r_out_valid;
    assign o_out_chan.scalar_value = r_out.scalar_value;
    assign o_out_chan.status       = r_out.status;
    assign o_out_chan.last_of_run  = r_out.last_of_run;

endmodule

/* dv/utf8_byte_stream_decoder_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the UTF-8 byte stream decoder: directed and random byte streams.
// Depends on utf8d_pkg, utf8d_in_if, utf8d_out_if and utf8_byte_stream_decoder_unit.
module utf8_byte_stream_decoder_unit_tb;

    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam int         TAIL_CYCLES = 32;
    localparam int         MAX_REPORTS = 10;

    logic i_clk;
    logic i_rst_n;

    utf8d_in_if  in_chan ();
    utf8d_out_if out_chan ();

    utf8_byte_stream_decoder_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_chan),
        .o_out_chan (out_chan)
    );

    // Decoder state mirrored by the testbench.
    logic [1:0]                 seq_left;
    logic [utf8d_pkg::CP_W-1:0] seq_acc;

    utf8d_pkg::t_result decode_run [2];
    int                 decode_run_len;
    utf8d_pkg::t_result expected_results [$];

    int   mismatch_count;
    int   items_sent;
    logic steady_flow;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("utf8_byte_stream_decoder_unit regression: fail");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_result(logic [utf8d_pkg::CP_W-1:0] cp,
                                       utf8d_pkg::t_status st);
        decode_run[decode_run_len].scalar_value = cp;
        decode_run[decode_run_len].status       = st;
        decode_run[decode_run_len].last_of_run  = 1'b0;
        decode_run_len++;
    endfunction

    function automatic void take_lead(logic [7:0] b);
        if (b <= ASCII_MAX) begin
            add_result({13'd0, b}, utf8d_pkg::ST_OK);
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            seq_acc  = {16'd0, b[4:0]};
            seq_left = 2'd1;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            seq_acc  = {17'd0, b[3:0]};
            seq_left = 2'd2;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            seq_acc  = {18'd0, b[2:0]};
            seq_left = 2'd3;
        end else begin
            add_result('0, utf8d_pkg::ST_BAD_LEAD);
        end
    endfunction

    // Works out the results of one accepted item and queues them.
    function automatic void decode_item(logic [7:0] b, logic e);
        decode_run_len = 0;
        if (e) begin
            add_result('0, (seq_left == 2'd0) ? utf8d_pkg::ST_EOF : utf8d_pkg::ST_TRUNC);
            seq_left = 2'd0;
            seq_acc  = '0;
        end else if (seq_left == 2'd0) begin
            take_lead(b);
        end else if (b >= CONT_LO && b <= CONT_HI) begin
            seq_acc  = {seq_acc[utf8d_pkg::CP_W-7:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0) begin
                add_result(seq_acc, utf8d_pkg::ST_OK);
                seq_acc = '0;
            end
        end else begin
            // The offending byte is decoded again as a lead byte.
            add_result('0, utf8d_pkg::ST_BAD_CONT);
            seq_left = 2'd0;
            seq_acc  = '0;
            take_lead(b);
        end
        if (decode_run_len > 0)
            decode_run[decode_run_len-1].last_of_run = 1'b1;
        for (int i = 0; i < decode_run_len; i++)
            expected_results.push_back(decode_run[i]);
    endfunction

    function automatic void note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $realtime, what);
    endfunction

    // Compares every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        utf8d_pkg::t_result want;
        if (i_rst_n && out_chan.valid && out_chan.ready) begin
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result cp=%h status=%0d last=%0d",
                    out_chan.scalar_value, out_chan.status, out_chan.last_of_run));
            end else begin
                want = expected_results.pop_front();
                if (out_chan.scalar_value !== want.scalar_value ||
                    out_chan.status !== want.status ||
                    out_chan.last_of_run !== want.last_of_run)
                    note_mismatch($sformatf(
                        "cp exp %h got %h, status exp %0d got %0d, last exp %0d got %0d",
                        want.scalar_value, out_chan.scalar_value, want.status,
                        out_chan.status, want.last_of_run, out_chan.last_of_run));
            end
        end
    end

    // Output back-pressure: bursts of ready with random stalls between them, ready held high in steady flow.
    initial begin
        int run;
        int stall;
        out_chan.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            out_chan.ready <= 1'b1;
            if (steady_flow) begin
                @(posedge i_clk);
            end else begin
                run   = $urandom_range(1, 16);
                stall = pick_gap();
                repeat (run) @(posedge i_clk);
                if (stall > 0) begin
                    out_chan.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge where the item was accepted.
    task automatic send_item(input logic [7:0] b, input logic e);
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0) begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_chan.valid      <= 1'b1;
        in_chan.byte_value <= b;
        in_chan.end_marker <= e;
        do @(posedge i_clk); while (!in_chan.ready);
        decode_item(b, e);
        items_sent++;
    endtask

    task automatic wait_for_results();
        in_chan.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_cont();
        return CONT_LO | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] rand_lead(int len);
        case (len)
            1:       return 8'($urandom_range(0, ASCII_MAX));
            2:       return 8'($urandom_range(LEAD2_LO, LEAD2_HI));
            3:       return 8'($urandom_range(LEAD3_LO, LEAD3_HI));
            default: return 8'($urandom_range(LEAD4_LO, LEAD4_HI));
        endcase
    endfunction

    task automatic send_well_formed();
        int len;
        len = $urandom_range(1, 4);
        send_item(rand_lead(len), 1'b0);
        for (int i = 1; i < len; i++) send_item(rand_cont(), 1'b0);
    endtask

    // A multi-byte sequence cut short by an end marker or a byte that is no continuation.
    task automatic send_broken();
        int len;
        int kept;
        logic [7:0] breaker;
        len  = $urandom_range(2, 4);
        kept = $urandom_range(1, len - 1);
        send_item(rand_lead(len), 1'b0);
        for (int i = 1; i < kept; i++) send_item(rand_cont(), 1'b0);
        if ($urandom_range(0, 3) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            breaker = 8'($urandom_range(0, 191));
            if (breaker >= CONT_LO) breaker = breaker + 8'h40;
            send_item(breaker, 1'b0);
        end
    endtask

    task automatic test_ascii_and_eof();
        send_item(8'h00, 1'b0);
        send_item(ASCII_MAX, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_multibyte_extremes();
        send_item(LEAD2_LO, 1'b0);
        send_item(CONT_LO, 1'b0);
        send_item(LEAD2_HI, 1'b0);
        send_item(CONT_HI, 1'b0);
        send_item(LEAD3_HI, 1'b0);
        send_item(CONT_HI, 1'b0);
        send_item(CONT_HI, 1'b0);
        // Highest lead of all gives a code point above the Unicode range.
        send_item(LEAD4_HI, 1'b0);
        send_item(CONT_HI, 1'b0);
        send_item(CONT_HI, 1'b0);
        send_item(CONT_HI, 1'b0);
    endtask

    task automatic test_bad_leads();
        send_item(CONT_LO, 1'b0);
        send_item(LEAD2_LO - 8'd1, 1'b0);
        send_item(LEAD4_HI + 8'd1, 1'b0);
        send_item(8'hFF, 1'b0);
    endtask

    task automatic test_broken_sequences();
        // End marker in the middle of a sequence, with a byte value that must be ignored.
        send_item(LEAD4_HI, 1'b0);
        send_item(8'h8F, 1'b0);
        send_item(8'hFF, 1'b1);
        // Bad continuation followed by an ASCII lead, then by a bad lead.
        send_item(8'hC3, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'hC3, 1'b0);
        send_item(LEAD2_LO - 8'd1, 1'b0);
        // Bad continuation that starts a new three-byte sequence.
        send_item(LEAD2_HI, 1'b0);
        send_item(8'hE2, 1'b0);
        send_item(8'h82, 1'b0);
        send_item(8'hAC, 1'b0);
    endtask

    task automatic test_random_stream(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)      send_well_formed();
            else if (pick < 82) send_broken();
            else if (pick < 95) send_item(8'($urandom_range(0, 255)), 1'b0);
            else                send_item(8'($urandom_range(0, 255)), 1'b1);
            if (pick == 0) wait_for_results();
        end
    endtask

    task automatic test_back_to_back(input int count);
        int stop_at;
        stop_at = items_sent + count;
        steady_flow = 1'b1;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) send_broken();
            else                           send_well_formed();
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        seq_left       = 2'd0;
        seq_acc        = '0;
        mismatch_count = 0;
        items_sent     = 0;
        steady_flow    = 1'b0;
        i_rst_n            <= 1'b0;
        in_chan.valid      <= 1'b0;
        in_chan.byte_value <= 8'h00;
        in_chan.end_marker <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ascii_and_eof();
        test_multibyte_extremes();
        test_bad_leads();
        test_broken_sequences();
        wait_for_results();
        test_random_stream(170);
        wait_for_results();
        test_back_to_back(60);
        test_random_stream(170);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("utf8_byte_stream_decoder_unit regression: pass");
        else
            $display("utf8_byte_stream_decoder_unit regression: fail");
        $finish;
    end

endmodule
